### sv/qdcm_pkg.sv
// ----------------------------------------------------------------------------
// qdcm_pkg: shared constants and types for the quaternion-to-DCM block
// Holds quotient width, pipeline depths and the word types used by every file.
// ----------------------------------------------------------------------------
package qdcm_pkg;

   localparam int QB        = 17;         // quotient bits kept before saturation
   localparam int DIV_LAT   = QB + 2;     // divider: load stage, QB steps, output
   localparam int FRONT_LAT = 3;          // input, product and sum stages
   localparam int MAG_W     = 33;         // |numerator| and norm, up to 2^32
   localparam int NUM_W     = 35;         // signed numerator

   typedef logic signed [15:0] comp_type;
   typedef logic [MAG_W-1:0]   mag_type;
   typedef logic signed [NUM_W-1:0] num_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } tag_type;

endpackage

### sv/qdcm_div.sv
// ----------------------------------------------------------------------------
// qdcm_div: pipelined restoring divider for one matrix entry
// Computes round(mag * 2^FRAC_BITS / den), one quotient bit per stage, then
// applies the sign and saturates to 16 bits.
// ----------------------------------------------------------------------------
module qdcm_div #(
   parameter int FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              neg,
   input  qdcm_pkg::mag_type mag,
   input  qdcm_pkg::mag_type den,
   output qdcm_pkg::comp_type res
);
   import qdcm_pkg::*;

   localparam int DW = (FRAC_BITS + 36 > MAG_W + QB + 2) ? FRAC_BITS + 36 : MAG_W + QB + 2;

   logic [DW-1:0] rem_ff [QB+1];
   logic [DW-1:0] vs_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];
   logic [DW-1:0] sub_w  [QB];
   logic          take_w [QB];
   logic [DW-1:0] rem_in;
   logic [DW-1:0] vs_in;
   logic [QB-1:0] q_fin;
   comp_type      res_in;
   comp_type      res_ff;

   // load: dividend carries the half-divisor for round-to-nearest
   assign rem_in = (DW'(mag) << (FRAC_BITS + 1)) + DW'(den);
   assign vs_in  = DW'(den) << 1;

   for (genvar i = 0; i < QB; i++) begin : g_step
      assign sub_w[i]  = vs_ff[i] << (QB - 1 - i);
      assign take_w[i] = rem_ff[i] >= sub_w[i];
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in;
      vs_ff[0]  <= vs_in;
      q_ff[0]   <= '0;
      neg_ff[0] <= neg;
      ovf_ff[0] <= rem_in >= (vs_in << QB);
      for (int i = 0; i < QB; i++) begin
         rem_ff[i+1] <= take_w[i] ? rem_ff[i] - sub_w[i] : rem_ff[i];
         vs_ff[i+1]  <= vs_ff[i];
         q_ff[i+1]   <= q_ff[i] | (QB'(take_w[i]) << (QB - 1 - i));
         neg_ff[i+1] <= neg_ff[i];
         ovf_ff[i+1] <= ovf_ff[i];
      end
   end

   assign q_fin = ovf_ff[QB] ? '1 : q_ff[QB];

   always_comb begin
      if (neg_ff[QB]) begin
         res_in = (q_fin > QB'(32768)) ? 16'sh8000 : comp_type'(-q_fin);
      end else begin
         res_in = (q_fin > QB'(32767)) ? 16'sh7fff : comp_type'(q_fin);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

### sv/quaternion_to_dcm_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_dcm_top: attitude quaternion to direction cosine matrix
// Normalizes a Q1.14 quaternion and emits the nine rounded, saturated
// matrix entries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_q_w/x/y/z and raise start; the word is taken at any edge where
//   start is high and busy is low. busy is always low: one word a cycle.
//   Each result word appears on rsp_* for one cycle with rsp_valid high,
//   once its request has passed 3 front stages and 19 divider stages.
//   Throughput is one word per cycle; the latency is set by the restoring
//   divider, one quotient bit per stage over 17 bits.
//   Entries equal round(num * 2^FRAC_BITS / norm^2), ties away from zero,
//   which matches normalizing by the square root first.
//   An all-zero quaternion gives rsp_zero_norm high and a zero matrix.
//   The receiver cannot stall: results must be taken when shown.
//   Reset clears the valid line; words in flight are dropped.
// ----------------------------------------------------------------------------
module quaternion_to_dcm_top #(
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  qdcm_pkg::comp_type req_q_w,
   input  qdcm_pkg::comp_type req_q_x,
   input  qdcm_pkg::comp_type req_q_y,
   input  qdcm_pkg::comp_type req_q_z,
   output logic               rsp_valid,
   output qdcm_pkg::comp_type rsp_r11,
   output qdcm_pkg::comp_type rsp_r12,
   output qdcm_pkg::comp_type rsp_r13,
   output qdcm_pkg::comp_type rsp_r21,
   output qdcm_pkg::comp_type rsp_r22,
   output qdcm_pkg::comp_type rsp_r23,
   output qdcm_pkg::comp_type rsp_r31,
   output qdcm_pkg::comp_type rsp_r32,
   output qdcm_pkg::comp_type rsp_r33,
   output logic               rsp_zero_norm
);
   import qdcm_pkg::*;

   // stage 1: capture the word
   comp_type w_ff, x_ff, y_ff, z_ff;
   logic     v1_ff;
   // stage 2: products
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic     v2_ff;
   // stage 3: norm and numerators
   num_type  num_ff [9];
   num_type  num_in [9];
   num_type  den_sum;
   mag_type  den_ff;
   tag_type  t3_ff;
   // divider latency line for valid and zero flag
   tag_type  line_ff [DIV_LAT];
   comp_type res [9];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         t3_ff <= '0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         t3_ff <= '{valid: v2_ff, zero: den_sum == '0};
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= req_q_w;
      x_ff  <= req_q_x;
      y_ff  <= req_q_y;
      z_ff  <= req_q_z;
      ww_ff <= w_ff * w_ff;
      xx_ff <= x_ff * x_ff;
      yy_ff <= y_ff * y_ff;
      zz_ff <= z_ff * z_ff;
      xy_ff <= x_ff * y_ff;
      wz_ff <= w_ff * z_ff;
      xz_ff <= x_ff * z_ff;
      wy_ff <= w_ff * y_ff;
      yz_ff <= y_ff * z_ff;
      wx_ff <= w_ff * x_ff;
   end

   // numerators of the standard form; off-diagonal terms doubled
   always_comb begin
      den_sum   = NUM_W'(ww_ff) + NUM_W'(xx_ff) + NUM_W'(yy_ff) + NUM_W'(zz_ff);
      num_in[0] = NUM_W'(ww_ff) + NUM_W'(xx_ff) - NUM_W'(yy_ff) - NUM_W'(zz_ff);
      num_in[1] = (NUM_W'(xy_ff) - NUM_W'(wz_ff)) <<< 1;
      num_in[2] = (NUM_W'(xz_ff) + NUM_W'(wy_ff)) <<< 1;
      num_in[3] = (NUM_W'(xy_ff) + NUM_W'(wz_ff)) <<< 1;
      num_in[4] = NUM_W'(ww_ff) - NUM_W'(xx_ff) + NUM_W'(yy_ff) - NUM_W'(zz_ff);
      num_in[5] = (NUM_W'(yz_ff) - NUM_W'(wx_ff)) <<< 1;
      num_in[6] = (NUM_W'(xz_ff) - NUM_W'(wy_ff)) <<< 1;
      num_in[7] = (NUM_W'(yz_ff) + NUM_W'(wx_ff)) <<< 1;
      num_in[8] = NUM_W'(ww_ff) - NUM_W'(xx_ff) - NUM_W'(yy_ff) + NUM_W'(zz_ff);
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_sum[MAG_W-1:0];
   end

   // one divider lane per entry; sign and magnitude split here
   for (genvar k = 0; k < 9; k++) begin : g_lane
      logic    neg;
      num_type neg_num;
      assign neg     = num_ff[k] < 0;
      assign neg_num = -num_ff[k];
      qdcm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .neg   (neg),
         .mag   (neg ? neg_num[MAG_W-1:0] : num_ff[k][MAG_W-1:0]),
         .den   (den_ff),
         .res   (res[k])
      );
   end

   // advance the tag alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         line_ff[0] <= t3_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   logic zo;
   assign zo            = line_ff[DIV_LAT-1].zero;
   assign rsp_valid     = line_ff[DIV_LAT-1].valid;
   assign rsp_zero_norm = rsp_valid && zo;
   // drop the divider result for a zero quaternion
   assign rsp_r11 = zo ? '0 : res[0];
   assign rsp_r12 = zo ? '0 : res[1];
   assign rsp_r13 = zo ? '0 : res[2];
   assign rsp_r21 = zo ? '0 : res[3];
   assign rsp_r22 = zo ? '0 : res[4];
   assign rsp_r23 = zo ? '0 : res[5];
   assign rsp_r31 = zo ? '0 : res[6];
   assign rsp_r32 = zo ? '0 : res[7];
   assign rsp_r33 = zo ? '0 : res[8];

   a_zero_matrix: assert property (@(posedge clock) disable iff (reset)
      rsp_zero_norm |-> (rsp_r11 == '0 && rsp_r22 == '0 && rsp_r33 == '0 &&
                         rsp_r12 == '0 && rsp_r21 == '0))
      else $error("zero quaternion gave nonzero matrix");

   a_zero_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_zero_norm |-> rsp_valid)
      else $error("zero flag without strobe");

   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("strobe right after reset");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the quaternion-to-DCM block
// Drives directed and random quaternions with random start gaps, predicts
// each matrix word with an exact rounded quotient, and checks every result.
// ----------------------------------------------------------------------------
module testbench;
   import qdcm_pkg::*;

   localparam int FRAC = 14;
   localparam int LATENCY = FRONT_LAT + DIV_LAT;
   localparam int WATCHDOG = 2000;
   localparam int N_RANDOM = 1600;

   // one expected result word: nine entries and the zero flag
   typedef struct {
      comp_type r[9];
      logic     zero;
   } dcm_word_type;

   // directed row: input plus an optional typed-in expected matrix
   typedef struct {
      comp_type q[4];
      bit       fixed;
      comp_type r[9];
      logic     zero;
   } dir_row_type;

   logic     clock, reset, start, busy;
   comp_type req_q_w, req_q_x, req_q_y, req_q_z;
   logic     rsp_valid, rsp_zero_norm;
   comp_type rsp_r[9];

   dcm_word_type expected_dcm[$];
   int           idle_cycles;
   int           errors;

   quaternion_to_dcm_top #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_q_w(req_q_w), .req_q_x(req_q_x), .req_q_y(req_q_y), .req_q_z(req_q_z),
      .rsp_valid(rsp_valid),
      .rsp_r11(rsp_r[0]), .rsp_r12(rsp_r[1]), .rsp_r13(rsp_r[2]),
      .rsp_r21(rsp_r[3]), .rsp_r22(rsp_r[4]), .rsp_r23(rsp_r[5]),
      .rsp_r31(rsp_r[6]), .rsp_r32(rsp_r[7]), .rsp_r33(rsp_r[8]),
      .rsp_zero_norm(rsp_zero_norm)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // round num * 2^FRAC / norm to nearest, ties away from zero, then saturate
   function automatic comp_type scaled_entry(longint num, longint norm);
      longint mag, quo;
      mag = (num < 0) ? -num : num;
      quo = ((mag <<< (FRAC + 1)) + norm) / (norm <<< 1);
      if (num < 0)
         return (quo > 32768) ? comp_type'(-32768) : comp_type'(-quo);
      return (quo > 32767) ? comp_type'(32767) : comp_type'(quo);
   endfunction

   function automatic dcm_word_type predict_dcm(comp_type qw, comp_type qx,
                                                comp_type qy, comp_type qz);
      dcm_word_type d;
      longint w, x, y, z, ww, xx, yy, zz, norm;
      longint num[9];
      w = qw; x = qx; y = qy; z = qz;
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      norm = ww + xx + yy + zz;
      d.zero = (norm == 0);
      if (norm == 0) begin
         foreach (d.r[i]) d.r[i] = '0;
         return d;
      end
      num[0] = ww + xx - yy - zz;
      num[1] = 2 * (x * y - w * z);
      num[2] = 2 * (x * z + w * y);
      num[3] = 2 * (x * y + w * z);
      num[4] = ww - xx + yy - zz;
      num[5] = 2 * (y * z - w * x);
      num[6] = 2 * (x * z - w * y);
      num[7] = 2 * (y * z + w * x);
      num[8] = ww - xx - yy + zz;
      foreach (num[i]) d.r[i] = scaled_entry(num[i], norm);
      return d;
   endfunction

   function automatic comp_type rand_comp();
      case ($urandom_range(0, 5))
         0: return comp_type'($urandom_range(0, 7) - 3);           // tiny: coarse ratios
         1: return $urandom_range(0, 1) ? comp_type'(32767) : comp_type'(-32768);
         2: return comp_type'($urandom_range(0, 16384) - 8192);   // near unit scale
         default: return comp_type'($urandom);
      endcase
   endfunction

   // check every result word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         dcm_word_type exp_w;
         if (expected_dcm.size() == 0) begin
            $error("result word with no expectation pending");
            errors++;
         end else begin
            exp_w = expected_dcm.pop_front();
            foreach (exp_w.r[i])
               if (rsp_r[i] !== exp_w.r[i]) begin
                  $error("r%0d%0d: expected %0d, got %0d", i / 3 + 1, i % 3 + 1,
                         exp_w.r[i], rsp_r[i]);
                  errors++;
               end
            if (rsp_zero_norm !== exp_w.zero) begin
               $error("zero_norm: expected %0b, got %0b", exp_w.zero, rsp_zero_norm);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles with nothing accepted on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // hold one word on the request ports until it is accepted
   task automatic send_word(comp_type qw, comp_type qx, comp_type qy, comp_type qz,
                            bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start   <= 1'b1;
      req_q_w <= qw; req_q_x <= qx; req_q_y <= qy; req_q_z <= qz;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_dcm.push_back(predict_dcm(qw, qx, qy, qz));
      @(negedge clock);
   endtask

   initial begin
      dir_row_type  rows[$];
      dir_row_type  row;
      dcm_word_type d;
      int           n;
      errors = 0;
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_q_w = '0; req_q_x = '0; req_q_y = '0; req_q_z = '0;

      // directed table: zero, identity, axis rotations, extremes, mixed signs
      row.fixed = 1'b1; row.zero = 1'b1;
      row.q = '{0, 0, 0, 0}; row.r = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; rows.push_back(row);
      row.zero = 1'b0;
      row.q = '{16384, 0, 0, 0};
      row.r = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; rows.push_back(row);
      row.q = '{-32768, 0, 0, 0}; rows.push_back(row);
      row.q = '{32767, 0, 0, 0}; rows.push_back(row);
      row.q = '{1, 0, 0, 0}; rows.push_back(row);
      row.q = '{0, -32768, 0, 0};
      row.r = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; rows.push_back(row);
      row.q = '{0, 0, 32767, 0};
      row.r = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; rows.push_back(row);
      row.q = '{0, 0, 0, -1};
      row.r = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; rows.push_back(row);
      row.fixed = 1'b0;
      row.q = '{32767, 32767, 32767, 32767}; rows.push_back(row);
      row.q = '{-32768, -32768, -32768, -32768}; rows.push_back(row);
      row.q = '{-32768, 32767, -32768, 32767}; rows.push_back(row);
      row.q = '{1, 1, 0, 0}; rows.push_back(row);
      row.q = '{1, 0, -1, 0}; rows.push_back(row);
      row.q = '{0, 1, 1, 1}; rows.push_back(row);
      row.q = '{3, -1, 2, -5}; rows.push_back(row);
      row.q = '{-21845, 10922, 5461, -1}; rows.push_back(row);
      row.q = '{11585, 0, 0, 11585}; rows.push_back(row);
      row.q = '{-1, -1, -1, -1}; rows.push_back(row);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table back to back; pin typed-in rows as well
      foreach (rows[i]) begin
         row = rows[i];
         if (row.fixed) begin
            d = predict_dcm(row.q[0], row.q[1], row.q[2], row.q[3]);
            foreach (d.r[k])
               if (d.r[k] !== row.r[k] || d.zero !== row.zero) begin
                  $error("directed row %0d: table and predictor disagree", i);
                  errors++;
               end
         end
         send_word(row.q[0], row.q[1], row.q[2], row.q[3], 1'b0);
      end

      // hold off until the pipe has drained once
      start <= 1'b0;
      while (expected_dcm.size() != 0) @(negedge clock);

      // random words; gaps only in the first three quarters
      for (n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 40) == 0)
            send_word(0, 0, 0, 0, n < N_RANDOM * 3 / 4);
         else
            send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      n < N_RANDOM * 3 / 4);
      end
      start <= 1'b0;

      // drain, then wait for stray result words before the verdict
      n = 0;
      while (expected_dcm.size() != 0 && n < 50 * LATENCY) begin
         @(negedge clock);
         n++;
      end
      repeat (2 * LATENCY) @(negedge clock);
      if (errors == 0 && expected_dcm.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
